// ===== rtl/vpa_pkg.sv =====
`default_nettype none
package vpa_pkg;
    localparam logic [1:0] POL_FIRST = 2'd0;
    localparam logic [1:0] POL_NEXT  = 2'd1;
    localparam logic [1:0] POL_BEST  = 2'd2;
    localparam logic [1:0] POL_WORST = 2'd3;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic [1:0] CFG_POLICY = 2'd0;
    localparam logic [1:0] CFG_POOL   = 2'd1;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [15:0] POOL_RESET = 16'd1024;
endpackage
`default_nettype wire

// ===== rtl/variable_partition_allocator.sv =====
// Sequence: accept, S_ROVER (next fit only, to find the rover entry), S_SCAN, S_APPLY,
// then S_SHDN or S_SHUP when the table must shift, then the result beat in S_OUT;
// zero-size, empty-table and out-of-pool requests go from accept straight to S_OUT.
// Throughput: one request at a time; in_stall is high from accept until the result beat.
// The scan and shift loops step one table entry per cycle.
// Reset (rst_n low, async): table holds one segment (0, 1024), fit_policy first fit.
`default_nettype none
module variable_partition_allocator #(
    parameter int MAX_SEGMENTS = 16,
    parameter int ADDR_BITS    = 16
) (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         in_valid,
    output logic        in_stall,
    input  wire         mode,
    input  wire  [15:0] req_size,
    input  wire  [15:0] free_addr,
    output logic        out_valid,
    input  wire         out_stall,
    output logic [1:0]  status,
    output logic [15:0] block_addr,
    input  wire         cfg_valid,
    output logic        cfg_ready,
    input  wire  [1:0]  cfg_index,
    input  wire  [15:0] cfg_data
);
    import vpa_pkg::*;

    localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int LW = ((ADDR_BITS > 16) ? ADDR_BITS : 16) + 1;
    localparam logic [CW-1:0] CMAX = CW'(MAX_SEGMENTS);
    localparam logic [LW-1:0] POOL_CAP = LW'(1) << ADDR_BITS;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ROVER = 3'd1;
    localparam logic [2:0] S_SCAN  = 3'd2;
    localparam logic [2:0] S_APPLY = 3'd3;
    localparam logic [2:0] S_SHDN  = 3'd4;
    localparam logic [2:0] S_SHUP  = 3'd5;
    localparam logic [2:0] S_OUT   = 3'd6;

    logic [LW-1:0] start_reg [MAX_SEGMENTS];
    logic [LW-1:0] len_reg   [MAX_SEGMENTS];
    logic [CW-1:0] cnt_reg;
    logic [LW-1:0] rover_reg;
    logic [1:0]    pol_reg;
    logic [15:0]   pool_reg;
    logic [2:0]    st_reg;
    logic [CW-1:0] i_reg, j_reg, first_reg, pick_reg;
    logic          found_reg;
    logic          mode_reg;
    logic [LW-1:0] size_reg, faddr_reg;
    logic [1:0]    status_reg;
    logic [15:0]   addr_reg;

    logic [IW-1:0] ix;
    logic [LW-1:0] cur_s, cur_l, f_end;
    logic [CW:0]   wrap;
    logic [CW-1:0] widx;
    logic [IW-1:0] pix;
    logic [LW-1:0] pool_lim;

    assign pool_lim = (LW'(pool_reg) > POOL_CAP) ? POOL_CAP : LW'(pool_reg);
    assign cfg_ready = (st_reg == S_IDLE) && !out_valid;
    assign in_stall  = (st_reg != S_IDLE) || cfg_valid;
    assign out_valid = (st_reg == S_OUT);
    assign status = status_reg;
    assign block_addr = addr_reg;

    always_comb
    begin
        wrap = {1'b0, first_reg} + {1'b0, j_reg};
        if (wrap >= {1'b0, cnt_reg})
            wrap = wrap - {1'b0, cnt_reg};
        widx = (pol_reg == POL_NEXT && mode_reg == MODE_ALLOC && st_reg == S_SCAN)
               ? wrap[CW-1:0] : i_reg;
        ix = widx[IW-1:0];
        cur_s = start_reg[ix];
        cur_l = len_reg[ix];
        f_end = faddr_reg + size_reg;
        pix = pick_reg[IW-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= CW'(1);
            rover_reg <= '0;
            pol_reg <= POL_FIRST;
            pool_reg <= POOL_RESET;
            st_reg <= S_IDLE;
            start_reg[0] <= '0;
            len_reg[0] <= LW'(POOL_RESET);
        end
        else
        begin
            case (st_reg)
                S_IDLE:
                begin
                    if (cfg_valid && cfg_ready)
                    begin
                        if (cfg_index == CFG_POLICY)
                            pol_reg <= cfg_data[1:0];
                        else if (cfg_index == CFG_POOL)
                        begin
                            pool_reg <= cfg_data;
                            rover_reg <= '0;
                            start_reg[0] <= '0;
                            len_reg[0] <= (LW'(cfg_data) > POOL_CAP) ? POOL_CAP
                                                                   : LW'(cfg_data);
                            cnt_reg <= (cfg_data == 16'd0) ? '0 : CW'(1);
                        end
                    end
                    else if (in_valid && !in_stall)
                    begin
                        mode_reg <= mode;
                        size_reg <= LW'(req_size);
                        faddr_reg <= LW'(free_addr);
                        i_reg <= '0;
                        j_reg <= '0;
                        first_reg <= '0;
                        found_reg <= 1'b0;
                        pick_reg <= '0;
                        addr_reg <= '0;
                        status_reg <= ST_OK;
                        if (mode == MODE_ALLOC && (req_size == 16'd0 || cnt_reg == '0))
                        begin
                            status_reg <= ST_NOFIT;
                            st_reg <= S_OUT;
                        end
                        else if (mode == MODE_FREE && (req_size == 16'd0 ||
                                 LW'(free_addr) + LW'(req_size) > pool_lim))
                            st_reg <= S_OUT;
                        else if (mode == MODE_ALLOC && pol_reg == POL_NEXT)
                            st_reg <= S_ROVER;
                        else
                            st_reg <= S_SCAN;
                    end
                end
                S_ROVER:
                begin
                    if (i_reg < cnt_reg && cur_s < rover_reg)
                        i_reg <= i_reg + CW'(1);
                    else
                    begin
                        first_reg <= (i_reg >= cnt_reg) ? '0 : i_reg;
                        i_reg <= '0;
                        st_reg <= S_SCAN;
                    end
                end
                S_SCAN:
                begin
                    if (mode_reg == MODE_FREE)
                    begin
                        if (i_reg < cnt_reg && cur_s <= faddr_reg)
                            i_reg <= i_reg + CW'(1);
                        else
                        begin
                            pick_reg <= i_reg;
                            st_reg <= S_APPLY;
                        end
                    end
                    else if (pol_reg == POL_NEXT)
                    begin
                        if (j_reg >= cnt_reg)
                        begin
                            status_reg <= ST_NOFIT;
                            st_reg <= S_OUT;
                        end
                        else if (cur_l >= size_reg)
                        begin
                            pick_reg <= widx;
                            found_reg <= 1'b1;
                            st_reg <= S_APPLY;
                        end
                        else
                            j_reg <= j_reg + CW'(1);
                    end
                    else
                    begin
                        if (i_reg >= cnt_reg || (found_reg && pol_reg == POL_FIRST))
                        begin
                            if (found_reg)
                                st_reg <= S_APPLY;
                            else
                            begin
                                status_reg <= ST_NOFIT;
                                st_reg <= S_OUT;
                            end
                        end
                        else
                        begin
                            if (cur_l >= size_reg && (!found_reg ||
                                (pol_reg == POL_BEST && cur_l < len_reg[pix]) ||
                                (pol_reg == POL_WORST && cur_l > len_reg[pix])))
                            begin
                                pick_reg <= i_reg;
                                found_reg <= 1'b1;
                            end
                            i_reg <= i_reg + CW'(1);
                        end
                    end
                end
                S_APPLY:
                begin
                    if (mode_reg == MODE_ALLOC)
                    begin
                        addr_reg <= 16'(start_reg[pix]);
                        rover_reg <= (start_reg[pix] + size_reg) & (POOL_CAP - LW'(1));
                        if (len_reg[pix] == size_reg)
                        begin
                            i_reg <= pick_reg;
                            st_reg <= S_SHDN;
                        end
                        else
                        begin
                            start_reg[pix] <= start_reg[pix] + size_reg;
                            len_reg[pix] <= len_reg[pix] - size_reg;
                            st_reg <= S_OUT;
                        end
                    end
                    else
                    begin
                        // pick = p; prev = p-1
                        logic hp, hn, jp, jn;
                        logic [IW-1:0] qix;
                        logic [LW-1:0] pend;
                        qix = IW'(pick_reg - CW'(1));
                        hp = pick_reg != '0;
                        hn = pick_reg < cnt_reg;
                        pend = start_reg[qix] + len_reg[qix];
                        jp = hp && pend == faddr_reg;
                        jn = hn && f_end == start_reg[pix];
                        st_reg <= S_OUT;
                        if ((hp && pend > faddr_reg) || (hn && f_end > start_reg[pix]))
                            st_reg <= S_OUT;
                        else if (jp && jn)
                        begin
                            len_reg[qix] <= pend - start_reg[qix] + size_reg
                                            + len_reg[pix];
                            i_reg <= pick_reg;
                            st_reg <= S_SHDN;
                        end
                        else if (jp)
                            len_reg[qix] <= len_reg[qix] + size_reg;
                        else if (jn)
                        begin
                            start_reg[pix] <= faddr_reg;
                            len_reg[pix] <= len_reg[pix] + size_reg;
                        end
                        else if (cnt_reg >= CMAX)
                            status_reg <= ST_FULL;
                        else
                        begin
                            i_reg <= cnt_reg;
                            st_reg <= S_SHUP;
                        end
                    end
                end
                S_SHDN:
                begin
                    if (i_reg + CW'(1) < cnt_reg)
                    begin
                        start_reg[ix] <= start_reg[IW'(i_reg + CW'(1))];
                        len_reg[ix] <= len_reg[IW'(i_reg + CW'(1))];
                        i_reg <= i_reg + CW'(1);
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg - CW'(1);
                        st_reg <= S_OUT;
                    end
                end
                S_SHUP:
                begin
                    if (i_reg > pick_reg)
                    begin
                        start_reg[ix] <= start_reg[IW'(i_reg - CW'(1))];
                        len_reg[ix] <= len_reg[IW'(i_reg - CW'(1))];
                        i_reg <= i_reg - CW'(1);
                    end
                    else
                    begin
                        start_reg[pix] <= faddr_reg;
                        len_reg[pix] <= size_reg;
                        cnt_reg <= cnt_reg + CW'(1);
                        st_reg <= S_OUT;
                    end
                end
                S_OUT:
                begin
                    if (!out_stall)
                        st_reg <= S_IDLE;
                end
                default:
                    st_reg <= S_IDLE;
            endcase
        end
    end

`ifndef ASSERT_OFF
    a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg <= CMAX)
        else $error("seg count overflow");
    a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg != S_IDLE) |-> in_stall) else $error("ready while busy");
    a_ok_addr: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status_reg != ST_OK) |-> addr_reg == '0)
        else $error("addr on error");
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> !out_valid) else $error("cfg while busy");
`endif
endmodule
`default_nettype wire
